FILE: design/json_string_unescape_utf8_core_defines.svh
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core_defines
// assertion macros shared by the string unescaper rtl
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, masked while in reset
`define JSU_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, masked while in reset
`define JSU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JSU_ASSERT_NOW(name, ante, cons, msg)
`define JSU_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

FILE: design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// types, codes and decode helpers for the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

  // default depth of the run queue between front and back
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // special characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  // utf-8 encoding constants
  localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
  localparam logic [7:0]  UTF8_CONT      = 8'h80;
  localparam logic [15:0] CP_1BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] CP_2BYTE_LIMIT = 16'h0800;

  // parser mode
  typedef enum logic [3:0] {
    MODE_WAIT = 4'b0001,
    MODE_STR  = 4'b0010,
    MODE_ESC  = 4'b0100,
    MODE_HEX  = 4'b1000
  } mode_t;

  // all results caused by one input byte: up to three bytes, then an optional tail
  typedef struct packed {
    logic [1:0]      nbytes;
    logic [2:0][7:0] data;
    logic            has_tail;
    logic [1:0]      tail_kind;
  } run_t;

  // front status
  typedef struct packed {
    logic  push;
    mode_t mode;
  } front_stat_t;

  // hex character decode: bit 4 flags a valid character
  function automatic logic [4:0] hex_nibble(logic [7:0] b);
    case (b) inside
      [8'h30:8'h39]:               return {1'b1, b[3:0]};
      [8'h41:8'h46], [8'h61:8'h66]: return {1'b1, b[3:0] + 4'd9};
      default:                     return 5'd0;
    endcase
  endfunction

  // single-character escape decode: bit 8 flags a known escape
  function automatic logic [8:0] esc_byte(logic [7:0] b);
    case (b)
      8'h22:   return {1'b1, 8'h22};
      8'h5C:   return {1'b1, 8'h5C};
      8'h2F:   return {1'b1, 8'h2F};
      8'h62:   return {1'b1, 8'h08};
      8'h66:   return {1'b1, 8'h0C};
      8'h6E:   return {1'b1, 8'h0A};
      8'h72:   return {1'b1, 8'h0D};
      8'h74:   return {1'b1, 8'h09};
      default: return 9'd0;
    endcase
  endfunction

endpackage

FILE: design/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_if
// valid/ready channels for raw input bytes and decoded results
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last_of_run;

  modport source (output valid, out_byte, kind, last_of_run, input ready);
  modport sink   (input valid, out_byte, kind, last_of_run, output ready);
endinterface

FILE: design/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// accepts raw bytes, tracks the parser mode and builds one run per byte
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic               clk,
  input  logic               rst_n,
  jsu_in_if.sink             in_ch,
  input  logic               fifo_full,
  output jsu_pkg::run_t      push_run,
  output jsu_pkg::front_stat_t stat
);
  import jsu_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic [15:0] cp_shift;
  logic [4:0]  hex;
  logic [8:0]  esc;
  logic [7:0]  b;
  logic        errored;
  logic        accept;
  run_t        run;

  assign in_ch.ready = !fifo_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign hex         = hex_nibble(b);
  assign esc         = esc_byte(b);
  assign cp_shift    = {cp_r[11:0], hex[3:0]};

  // next state and run contents for the current byte
  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    cp_nxt   = cp_r;
    run      = '0;
    errored  = 1'b0;
    case (mode_r)
      MODE_WAIT: begin
        if (b == CH_QUOTE) begin
          mode_nxt = MODE_STR;
        end else begin
          errored = 1'b1;
        end
      end
      MODE_STR: begin
        if (b == CH_QUOTE) begin
          run.has_tail  = 1'b1;
          run.tail_kind = KIND_DONE;
          mode_nxt      = MODE_WAIT;
          cnt_nxt       = 2'd0;
          cp_nxt        = 16'd0;
        end else if (b == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          run.nbytes  = 2'd1;
          run.data[0] = b;
        end
      end
      MODE_ESC: begin
        if (esc[8]) begin
          run.nbytes  = 2'd1;
          run.data[0] = esc[7:0];
          mode_nxt    = MODE_STR;
        end else if (b == CH_U) begin
          mode_nxt = MODE_HEX;
          cnt_nxt  = 2'd0;
          cp_nxt   = 16'd0;
        end else begin
          errored = 1'b1;
        end
      end
      MODE_HEX: begin
        if (!hex[4]) begin
          errored = 1'b1;
        end else if (cnt_r != 2'd3) begin
          cp_nxt  = cp_shift;
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          // fourth digit: encode the code point as utf-8
          if (cp_shift < CP_1BYTE_LIMIT) begin
            run.nbytes  = 2'd1;
            run.data[0] = cp_shift[7:0];
          end else if (cp_shift < CP_2BYTE_LIMIT) begin
            run.nbytes  = 2'd2;
            run.data[0] = UTF8_LEAD2 | {3'b000, cp_shift[10:6]};
            run.data[1] = UTF8_CONT | {2'b00, cp_shift[5:0]};
          end else begin
            run.nbytes  = 2'd3;
            run.data[0] = UTF8_LEAD3 | {4'b0000, cp_shift[15:12]};
            run.data[1] = UTF8_CONT | {2'b00, cp_shift[11:6]};
            run.data[2] = UTF8_CONT | {2'b00, cp_shift[5:0]};
          end
          mode_nxt = MODE_STR;
          cnt_nxt  = 2'd0;
          cp_nxt   = 16'd0;
        end
      end
      default: begin
        mode_nxt = MODE_WAIT;
        cnt_nxt  = 2'd0;
        cp_nxt   = 16'd0;
      end
    endcase

    // truncated input while a string is still open
    if (in_ch.end_of_input && !errored && mode_nxt != MODE_WAIT) begin
      errored = 1'b1;
    end

    // any fault ends the string
    if (errored) begin
      run.has_tail  = 1'b1;
      run.tail_kind = KIND_ERR;
      mode_nxt      = MODE_WAIT;
      cnt_nxt       = 2'd0;
      cp_nxt        = 16'd0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_WAIT;
      cnt_r  <= 2'd0;
      cp_r   <= 16'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      cp_r   <= cp_nxt;
    end
  end

  // only non-empty runs enter the queue
  assign push_run  = run;
  assign stat.push = accept && (run.nbytes != 2'd0 || run.has_tail);
  assign stat.mode = mode_r;

endmodule

FILE: design/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo
// short queue of runs between the front and the back
// ----------------------------------------------------------------------------
module jsu_fifo #(
  parameter int unsigned DEPTH = jsu_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::run_t push_run,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output jsu_pkg::run_t head
);
  import jsu_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  run_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = store[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // run storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr_r] <= push_run;
    end
  end

endmodule

FILE: design/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// walks the head run, one result per unstalled cycle, into the output register
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  jsu_pkg::run_t head,
  output logic          pop,
  jsu_out_if.source     out_ch
);
  import jsu_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r, sel_byte;
  logic [1:0] kind_r, sel_kind;
  logic       last_r;
  logic [2:0] run_len;
  logic       is_last;
  logic       load;

  assign run_len = {1'b0, head.nbytes} + {2'b00, head.has_tail};
  assign is_last = ({1'b0, idx_r} == run_len - 3'd1);
  assign load    = !out_valid_r || out_ch.ready;
  assign pop     = load && head_valid && is_last;

  // pick the result at the current position of the run
  always_comb begin
    sel_byte = 8'd0;
    sel_kind = head.tail_kind;
    if (idx_r < head.nbytes) begin
      sel_kind = KIND_BYTE;
      case (idx_r)
        2'd0:    sel_byte = head.data[0];
        2'd1:    sel_byte = head.data[1];
        2'd2:    sel_byte = head.data[2];
        default: sel_byte = 8'd0;
      endcase
    end
  end

  // position within the run
  always_comb begin
    idx_nxt = idx_r;
    if (load && head_valid) begin
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= head_valid;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte_r <= sel_byte;
      kind_r     <= sel_kind;
      last_r     <= is_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.last_of_run = last_r;

endmodule

FILE: design/json_string_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// streaming json string unescaper with utf-8 output for \u escapes
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one raw byte per beat, from the opening quote onward, with
//   end_of_input set on the last available byte. out_ch carries one result per
//   beat: a decoded byte (kind 0), string complete (kind 1) or error (kind 2);
//   last_of_run marks the final result caused by an input byte.
//   path: each result is written into the run queue, then loaded into the
//   output register that drives out_ch.
//   throughput: one input byte per cycle while each byte yields at most one
//   result and out_ch is ready; the back end emits one result per cycle while
//   out_ch is ready, so a \u escape giving three utf-8 bytes holds it for each
//   byte in turn, absorbed by the run queue of FIFO_DEPTH entries.
//   reset: synchronous, active low; clears the parser to wait for an opening
//   quote and empties the queue and output register.
//   stall: a low out_ch ready holds the output register; the queue fills, and
//   in_ch ready drops only once it is full.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_core_defines.svh"

module json_string_unescape_utf8_core #(
  parameter int unsigned FIFO_DEPTH = jsu_pkg::FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  run_t        push_run;
  run_t        head;
  front_stat_t stat;
  logic        fifo_full;
  logic        head_valid;
  logic        pop;

  // classify bytes and build runs
  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .fifo_full(fifo_full),
    .push_run (push_run),
    .stat     (stat)
  );

  // run queue
  jsu_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (stat.push),
    .push_run  (push_run),
    .pop       (pop),
    .full      (fifo_full),
    .head_valid(head_valid),
    .head      (head)
  );

  // serialise runs onto the result channel
  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  // checks
  `JSU_ASSERT_NOW(a_no_push_when_full, stat.push, !fifo_full, "run pushed into a full queue")
  `JSU_ASSERT_NEXT(a_end_closes_string, in_ch.valid && in_ch.ready && in_ch.end_of_input, stat.mode == MODE_WAIT, "string still open after last input byte")
  `JSU_ASSERT_NOW(a_tail_is_last, out_ch.valid && out_ch.kind != KIND_BYTE, out_ch.last_of_run, "completion or error not last of its run")

endmodule
